// File: sv/rllt_pkg.sv
// Shared constants, status codes and result type of the run-length line table.
`default_nettype none

package rllt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int OFS_W = 24;
	localparam int LINE_W = 24;
	localparam int RUN_W = 8;
	localparam int ENTRY_W = RUN_W + LINE_W;
	localparam int CAP_W = CNT_W + RUN_W;
	localparam int CMP_W = (CAP_W > OFS_W) ? CAP_W : OFS_W;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
	localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_OFFSET   = 3'd1;
	localparam status_t ST_LINE     = 3'd2;
	localparam status_t ST_FULL     = 3'd3;
	localparam status_t ST_NOTFOUND = 3'd4;

	typedef struct packed {
		status_t            status;
		logic [LINE_W-1:0]  found_line;
	} rllt_result_t;

endpackage

`default_nettype wire

// File: sv/rllt_ctrl.sv
// Sequencer that owns the run table memory and performs records and lookups on it.
`default_nettype none

module rllt_ctrl
	import rllt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic              op,
	input  wire logic [OFS_W-1:0]  code_offset,
	input  wire logic [LINE_W-1:0] source_line,
	output logic                   res_valid,
	output rllt_result_t           res,
	input  wire logic              res_take
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_REVAL  = 3'd1;
	localparam logic [2:0] S_APPEND = 3'd2;
	localparam logic [2:0] S_LOOK   = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [ENTRY_W-1:0] run_entries [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	logic [2:0]        state_q, state_d;
	logic [CNT_W-1:0]  used_q, used_d;
	logic [OFS_W-1:0]  last_ofs_q, last_ofs_d;
	logic              pend_s1, pend_d;
	logic [OFS_W-1:0]  ofs_q, ofs_d;
	logic [LINE_W-1:0] line_q, line_d;
	logic [OFS_W-1:0]  amount_q, amount_d;
	logic [OFS_W-1:0]  run_q, run_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	rllt_result_t      res_q, res_d;

	logic [CNT_W-1:0]  last_idx;
	logic [CNT_W-1:0]  free;
	logic [CAP_W-1:0]  cap;
	logic [RUN_W-1:0]  last_cnt;
	logic [LINE_W-1:0] last_line;
	logic [RUN_W-1:0]  space;
	logic [RUN_W-1:0]  fill;
	logic [OFS_W-1:0]  rest;
	logic              same_line;
	logic [OFS_W-1:0]  need_amt;
	logic              room;
	logic [RUN_W-1:0]  chunk;
	logic [OFS_W:0]    sum;
	logic              hit;
	logic              accept;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	assign last_idx  = used_q - CNT_W'(1);
	assign free      = DEPTH_CNT - used_q;
	assign cap       = (CAP_W'(free) << RUN_W) - CAP_W'(free);
	assign last_cnt  = rd_data_q[ENTRY_W-1:LINE_W];
	assign last_line = rd_data_q[LINE_W-1:0];
	assign space     = RUN_MAX - last_cnt;
	assign fill      = (amount_q > OFS_W'(space)) ? space : amount_q[RUN_W-1:0];
	assign rest      = amount_q - OFS_W'(fill);
	assign same_line = (line_q == last_line);
	assign need_amt  = same_line ? rest : amount_q;
	assign room      = CMP_W'(need_amt) <= CMP_W'(cap);
	assign chunk     = (amount_q > OFS_W'(RUN_MAX)) ? RUN_MAX : amount_q[RUN_W-1:0];
	assign sum       = (OFS_W + 1)'(run_q) + (OFS_W + 1)'(last_cnt);
	assign hit       = sum >= (OFS_W + 1)'(ofs_q);

	always_comb begin
		state_d    = state_q;
		used_d     = used_q;
		last_ofs_d = last_ofs_q;
		pend_d     = pend_s1;
		ofs_d      = ofs_q;
		line_d     = line_q;
		amount_d   = amount_q;
		run_d      = run_q;
		idx_d      = idx_q;
		res_d      = res_q;
		mem_we     = 1'b0;
		mem_waddr  = last_idx[IDX_W-1:0];
		mem_wdata  = {RUN_W'(0), line_q};
		rd_addr    = last_idx[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					ofs_d  = code_offset;
					line_d = source_line;
					res_d  = '{status: ST_OK, found_line: '0};
					if (!op) begin
						if (used_q == '0) begin
							mem_we     = 1'b1;
							mem_waddr  = '0;
							mem_wdata  = {RUN_W'(0), source_line};
							used_d     = CNT_W'(1);
							last_ofs_d = code_offset;
							state_d    = S_DONE;
						end else if (code_offset <= last_ofs_q) begin
							res_d.status = ST_OFFSET;
							state_d      = S_DONE;
						end else begin
							amount_d = code_offset - last_ofs_q;
							state_d  = S_REVAL;
						end
					end else begin
						if (used_q == '0 || code_offset > last_ofs_q) begin
							res_d.status = ST_NOTFOUND;
							state_d      = S_DONE;
						end else begin
							idx_d   = '0;
							run_d   = '0;
							pend_d  = 1'b0;
							state_d = S_LOOK;
						end
					end
				end
			end
			S_REVAL: begin
				if (!same_line && line_q < last_line) begin
					res_d.status = ST_LINE;
					state_d      = S_DONE;
				end else if (!room) begin
					res_d.status = ST_FULL;
					state_d      = S_DONE;
				end else begin
					last_ofs_d = ofs_q;
					state_d    = S_APPEND;
					if (same_line) begin
						mem_we    = 1'b1;
						mem_waddr = last_idx[IDX_W-1:0];
						mem_wdata = {last_cnt + fill, line_q};
						amount_d  = rest;
					end
				end
			end
			S_APPEND: begin
				if (amount_q == '0) begin
					state_d = S_DONE;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = used_q[IDX_W-1:0];
					mem_wdata = {chunk, line_q};
					used_d    = used_q + CNT_W'(1);
					amount_d  = amount_q - OFS_W'(chunk);
				end
			end
			S_LOOK: begin
				rd_addr = idx_q[IDX_W-1:0];
				if (pend_s1 && hit) begin
					res_d   = '{status: ST_OK, found_line: last_line};
					pend_d  = 1'b0;
					state_d = S_DONE;
				end else begin
					if (pend_s1) begin
						run_d = sum[OFS_W-1:0];
					end
					if (idx_q < used_q) begin
						idx_d  = idx_q + CNT_W'(1);
						pend_d = 1'b1;
					end else begin
						pend_d = 1'b0;
						if (!pend_s1) begin
							res_d.status = ST_NOTFOUND;
							state_d      = S_DONE;
						end
					end
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			run_entries[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= run_entries[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			last_ofs_q <= '0;
			pend_s1    <= 1'b0;
		end else begin
			state_q    <= state_d;
			used_q     <= used_d;
			last_ofs_q <= last_ofs_d;
			pend_s1    <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		ofs_q    <= ofs_d;
		line_q   <= line_d;
		amount_q <= amount_d;
		run_q    <= run_d;
		idx_q    <= idx_d;
		res_q    <= res_d;
	end

endmodule

`default_nettype wire

// File: sv/rllt_rsp.sv
// Output register that holds one result word until the receiver takes it.
`default_nettype none

module rllt_rsp
	import rllt_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          res_valid,
	input  wire rllt_result_t  res,
	output logic               res_take,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output status_t            status,
	output logic [LINE_W-1:0]  found_line
);

	logic         valid_q;
	rllt_result_t data_q;

	assign res_take   = !valid_q || !rsp_stall;
	assign rsp_valid  = valid_q;
	assign status     = data_q.status;
	assign found_line = data_q.found_line;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_take) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			data_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: sv/run_length_line_table_top.sv
// Top level of the run-length line table: sequencer with run memory and output register.
//
// Request channel (req_valid, req_stall): op 0 records a code_offset/source_line pair,
// op 1 looks up the line of code_offset. Each request word yields one response word
// (status, found_line) on the response channel (rsp_valid, rsp_stall).
// One request is worked on at a time; req_stall is high from acceptance until the
// result has moved into the output register.
// A first record, a record whose offset does not rise and a lookup past the end go
// straight to the result; a record whose line falls or that finds no room in the table
// is refused in the check state that follows. A record that passes the checks tops up
// the last run if its line is the same and then appends its new runs. A lookup walks the
// entries from zero until the running sum reaches its offset or all used entries are
// read: the walk reads one entry per cycle through the single read port.
// Reset empties the table at once; the memory contents need no clearing.
// While the receiver stalls, the response word holds and the block may finish one more
// request, then holds it and stalls the request channel until the output frees.
`default_nettype none

module run_length_line_table_top
	import rllt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic              op,
	input  wire logic [OFS_W-1:0]  code_offset,
	input  wire logic [LINE_W-1:0] source_line,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output status_t                status,
	output logic [LINE_W-1:0]      found_line
);

	logic         res_valid;
	logic         res_take;
	rllt_result_t res;

	rllt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.code_offset (code_offset),
		.source_line (source_line),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take)
	);

	rllt_rsp u_rsp (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.found_line (found_line)
	);

endmodule

`default_nettype wire

// File: sv/rllt_check.sv
// Port-level assertions of the run-length line table and their bind to the top level.
`default_nettype none

module rllt_check
	import rllt_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_stall,
	input wire logic              rsp_valid,
	input wire logic              rsp_stall,
	input wire status_t           status,
	input wire logic [LINE_W-1:0] found_line
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(found_line))
		else $error("Stalled response word changed.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("Request channel not stalled while a request is at work.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= ST_NOTFOUND)
		else $error("Response carries an undefined status.");

	a_line_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> found_line == '0)
		else $error("Failed request returned a nonzero line.");

endmodule

bind run_length_line_table_top rllt_check u_rllt_check (.*);

`default_nettype wire
